### design/vrefr_pkg.sv
`default_nettype none
package vrefr_pkg;

  // One vector component, signed Q4.F.
  typedef logic signed [15:0] comp_t;

  // Geometry of one item, carried down the pipeline next to the arithmetic.
  typedef struct packed {
    comp_t [2:0] inc;
    comp_t [2:0] nrm;
    logic  [14:0] eta;
  } ray_t;

  localparam int COMP_W = 16;
  localparam int ETA_W  = 15;

  localparam comp_t OUT_MAX = 16'sh7FFF;
  localparam comp_t OUT_MIN = 16'sh8000;

endpackage
`default_nettype wire

### design/vector_refraction.sv
`default_nettype none
// Channel | Direction | Handshake           | Item
// --------+-----------+---------------------+--------------------------------------------
// in_     | input     | in_valid / in_stall | incident I, normal N (Q4.F), eta (Q3.F)
// out_    | output    | out_valid/out_stall | refracted vector (Q4.F), total_internal, saturated
//
// One item enters per clock while in_stall is low. SW is the number of result bits
// of the square root of k, one bit per stage (SW = 26 at FRAC_BITS = 12).
// The square-root ladder sets the depth. Reset (synchronous, active low)
// clears only the valid bits. A stall while a result waits at the output freezes
// every stage together, so no item is lost or repeated; a stall with no result
// waiting is ignored, and while the output is not stalled, items flow on.
module vector_refraction #(
  parameter int FRAC_BITS = 12
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire  signed [15:0]        in_incident_x,
  input  wire  signed [15:0]        in_incident_y,
  input  wire  signed [15:0]        in_incident_z,
  input  wire  signed [15:0]        in_normal_x,
  input  wire  signed [15:0]        in_normal_y,
  input  wire  signed [15:0]        in_normal_z,
  input  wire         [14:0]        in_eta_ratio,
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic signed [15:0]        out_refracted_x,
  output logic signed [15:0]        out_refracted_y,
  output logic signed [15:0]        out_refracted_z,
  output logic                      out_total_internal,
  output logic                      out_saturated
);

  // Widths of every intermediate follow from the fraction width.
  localparam int IW   = vrefr_pkg::COMP_W;
  localparam int EW   = vrefr_pkg::ETA_W;
  localparam int F2   = 2 * FRAC_BITS;
  localparam int PW   = 2 * IW;                  // I_i * N_i
  localparam int DW   = PW + 2;                  // dot product
  localparam int CW   = DW - FRAC_BITS;          // cosi
  localparam int CCW  = 2 * CW;                  // cosi^2
  localparam int OPW  = ((CCW > F2 + 2) ? CCW : F2 + 2) + 1;
  localparam int OMW  = OPW - FRAC_BITS;         // 1 - cosi^2
  localparam int E2W  = 2 * EW - FRAC_BITS;      // eta^2, non-negative
  localparam int EKW  = E2W + 1 + OMW;           // eta^2 * (1 - cosi^2)
  localparam int KW   = ((EKW > F2 + 2) ? EKW : F2 + 2) + 1;
  localparam int KU   = KW - 1;                  // magnitude bits of k
  localparam int SW   = (KU + 1) / 2;            // square-root result bits
  localparam int RW   = 2 * SW + 1;              // square-root working width
  localparam int ECW  = EW + 1 + CW;             // eta * cosi
  localparam int ECSW = ECW - FRAC_BITS;
  localparam int MUW  = ((ECSW > SW + 1) ? ECSW : SW + 1) + 1;
  localparam int MNW  = MUW + IW;                // mu * N_i
  localparam int EIW  = EW + 1 + IW;             // eta * I_i
  localparam int RDW  = ((MNW > EIW) ? MNW : EIW) + 1;
  localparam int RSW  = RDW - FRAC_BITS;
  localparam int NST  = 9 + SW;                  // pipeline stages

  localparam logic signed [OPW-1:0] ONE2_OM = OPW'(1) << F2;
  localparam logic signed [KW-1:0]  ONE2_K  = KW'(1) << F2;

  // The whole pipeline moves when the output register is free or being taken.
  logic adv;
  logic vld_r [NST];

  assign adv       = !vld_r[NST-1] || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < NST; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // Stage 1: the three products of the dot product and eta squared.
  vrefr_pkg::ray_t          ray_nxt, ray1_r;
  logic signed [PW-1:0]     p_nxt [3];
  logic signed [PW-1:0]     p_r [3];
  logic        [2*EW-1:0]   eta2_nxt, eta2_r;

  always_comb begin
    ray_nxt.inc[0] = in_incident_x;
    ray_nxt.inc[1] = in_incident_y;
    ray_nxt.inc[2] = in_incident_z;
    ray_nxt.nrm[0] = in_normal_x;
    ray_nxt.nrm[1] = in_normal_y;
    ray_nxt.nrm[2] = in_normal_z;
    ray_nxt.eta    = in_eta_ratio;
    p_nxt[0] = in_incident_x * in_normal_x;
    p_nxt[1] = in_incident_y * in_normal_y;
    p_nxt[2] = in_incident_z * in_normal_z;
    eta2_nxt = in_eta_ratio * in_eta_ratio;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ray1_r <= ray_nxt;
      for (int i = 0; i < 3; i++) p_r[i] <= p_nxt[i];
      eta2_r <= eta2_nxt;
    end
  end

  // Stage 2: sum the products and drop the extra fraction bits (floor).
  vrefr_pkg::ray_t          ray2_r;
  logic signed [DW-1:0]     dot;
  logic signed [CW-1:0]     c_nxt, c2_r;
  logic        [E2W-1:0]    e2_nxt, e2_2_r;

  always_comb begin
    dot    = p_r[0] + p_r[1] + p_r[2];
    c_nxt  = CW'(dot >>> FRAC_BITS);
    e2_nxt = E2W'(eta2_r >> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ray2_r <= ray1_r;
      c2_r   <= c_nxt;
      e2_2_r <= e2_nxt;
    end
  end

  // Stage 3: cosi squared and eta times cosi.
  vrefr_pkg::ray_t          ray3_r;
  logic signed [CCW-1:0]    cc_nxt, cc3_r;
  logic signed [ECW-1:0]    ec_nxt, ec3_r;
  logic        [E2W-1:0]    e2_3_r;

  always_comb begin
    cc_nxt = c2_r * c2_r;
    ec_nxt = signed'({1'b0, ray2_r.eta}) * c2_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ray3_r <= ray2_r;
      cc3_r  <= cc_nxt;
      ec3_r  <= ec_nxt;
      e2_3_r <= e2_2_r;
    end
  end

  // Stage 4: one minus cosi squared, and eta*cosi back to F fraction bits.
  vrefr_pkg::ray_t          ray4_r;
  logic signed [OPW-1:0]    om_pre;
  logic signed [OMW-1:0]    om_nxt, om4_r;
  logic signed [ECSW-1:0]   ecs_nxt, ecs4_r;
  logic        [E2W-1:0]    e2_4_r;

  always_comb begin
    om_pre  = ONE2_OM - cc3_r;
    om_nxt  = OMW'(om_pre >>> FRAC_BITS);
    ecs_nxt = ECSW'(ec3_r >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ray4_r <= ray3_r;
      om4_r  <= om_nxt;
      ecs4_r <= ecs_nxt;
      e2_4_r <= e2_3_r;
    end
  end

  // Stage 5: eta^2 * (1 - cosi^2).
  vrefr_pkg::ray_t          ray5_r;
  logic signed [EKW-1:0]    ek_nxt, ek5_r;
  logic signed [ECSW-1:0]   ecs5_r;

  assign ek_nxt = signed'({1'b0, e2_4_r}) * om4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ray5_r <= ray4_r;
      ek5_r  <= ek_nxt;
      ecs5_r <= ecs4_r;
    end
  end

  // Stage 6: k and the total internal reflection decision. A negative k feeds
  // zero into the square root; its result is discarded at the output anyway.
  logic signed [KW-1:0]     k6;
  logic                     tir6;
  vrefr_pkg::ray_t          sq_ray_r [SW+1];
  logic signed [ECSW-1:0]   sq_ecs_r [SW+1];
  logic                     sq_tir_r [SW+1];
  logic        [RW-1:0]     sq_v_r   [SW+1];
  logic        [RW-1:0]     sq_res_r [SW+1];

  always_comb begin
    k6   = ONE2_K - ek5_r;
    tir6 = k6[KW-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_ray_r[0] <= ray5_r;
      sq_ecs_r[0] <= ecs5_r;
      sq_tir_r[0] <= tir6;
      sq_v_r[0]   <= tir6 ? '0 : RW'(k6[KU-1:0]);
      sq_res_r[0] <= '0;
    end
  end

  // Square-root ladder: each stage settles one result bit, from the top down,
  // with one compare and one subtract on the running remainder.
  for (genvar j = 0; j < SW; j++) begin : g_sqrt
    localparam logic [RW-1:0] BITC = RW'(1) << (2 * (SW - 1 - j));
    logic [RW-1:0] trial;
    logic [RW-1:0] v_nxt;
    logic [RW-1:0] res_nxt;

    always_comb begin
      trial = sq_res_r[j] + BITC;
      if (sq_v_r[j] >= trial) begin
        v_nxt   = sq_v_r[j] - trial;
        res_nxt = (sq_res_r[j] >> 1) + BITC;
      end else begin
        v_nxt   = sq_v_r[j];
        res_nxt = sq_res_r[j] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_ray_r[j+1] <= sq_ray_r[j];
        sq_ecs_r[j+1] <= sq_ecs_r[j];
        sq_tir_r[j+1] <= sq_tir_r[j];
        sq_v_r[j+1]   <= v_nxt;
        sq_res_r[j+1] <= res_nxt;
      end
    end
  end

  // mu = floor(eta*cosi) + sqrt(k).
  vrefr_pkg::ray_t          ray_mu_r;
  logic                     tir_mu_r;
  logic signed [MUW-1:0]    mu_nxt, mu_r;

  assign mu_nxt = sq_ecs_r[SW] + signed'({1'b0, sq_res_r[SW][SW-1:0]});

  always_ff @(posedge clk) begin
    if (adv) begin
      ray_mu_r <= sq_ray_r[SW];
      tir_mu_r <= sq_tir_r[SW];
      mu_r     <= mu_nxt;
    end
  end

  // Per component: eta*I_i and mu*N_i.
  logic signed [MNW-1:0]    mn_nxt [3];
  logic signed [MNW-1:0]    mn_r   [3];
  logic signed [EIW-1:0]    ei_nxt [3];
  logic signed [EIW-1:0]    ei_r   [3];
  logic                     tir_ml_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mn_nxt[i] = mu_r * signed'(ray_mu_r.nrm[i]);
      ei_nxt[i] = signed'({1'b0, ray_mu_r.eta}) * signed'(ray_mu_r.inc[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tir_ml_r <= tir_mu_r;
      for (int i = 0; i < 3; i++) begin
        mn_r[i] <= mn_nxt[i];
        ei_r[i] <= ei_nxt[i];
      end
    end
  end

  // Difference, floor back to F fraction bits and clip to 16 bits. Total
  // internal reflection forces a zero vector with no clip flag.
  vrefr_pkg::comp_t         rf_nxt [3];
  vrefr_pkg::comp_t         rf_r   [3];
  logic                     clip [3];
  logic                     sat_nxt, sat_r, tir_r;
  logic signed [RDW-1:0]    diff [3];
  logic signed [RSW-1:0]    shr  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = ei_r[i] - mn_r[i];
      shr[i]  = RSW'(diff[i] >>> FRAC_BITS);
      if (shr[i] > RSW'(vrefr_pkg::OUT_MAX)) begin
        rf_nxt[i] = vrefr_pkg::OUT_MAX;
        clip[i]   = 1'b1;
      end else if (shr[i] < RSW'(vrefr_pkg::OUT_MIN)) begin
        rf_nxt[i] = vrefr_pkg::OUT_MIN;
        clip[i]   = 1'b1;
      end else begin
        rf_nxt[i] = IW'(shr[i]);
        clip[i]   = 1'b0;
      end
      if (tir_ml_r) begin
        rf_nxt[i] = '0;
        clip[i]   = 1'b0;
      end
    end
    sat_nxt = clip[0] || clip[1] || clip[2];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) rf_r[i] <= rf_nxt[i];
      sat_r <= sat_nxt;
      tir_r <= tir_ml_r;
    end
  end

  assign out_refracted_x    = rf_r[0];
  assign out_refracted_y    = rf_r[1];
  assign out_refracted_z    = rf_r[2];
  assign out_total_internal = tir_r;
  assign out_saturated      = sat_r;

endmodule
`default_nettype wire

### tb/sv/vrefr_tb_pkg.sv
`timescale 1ns / 1ps
package vrefr_tb_pkg;
  import vrefr_pkg::*;

  localparam int FRAC = 12;

  // One result of the refraction unit: direction in Q4.FRAC and the two flags.
  typedef struct packed {
    comp_t [2:0] dir;
    logic        tir;
    logic        sat;
  } refr_result_t;

  class refraction_scoreboard;
    refr_result_t expected_refr[$];
    int errors    = 0;
    int n_rays    = 0;
    int n_checked = 0;
    int n_tir     = 0;
    int n_sat     = 0;

    // Integer square root, rounded down, by setting one result bit at a time.
    static function longint floor_root(longint v);
      longint unsigned val;
      longint unsigned root;
      longint unsigned trial;
      int b;
      val  = v;
      root = 0;
      for (b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= val) begin
          root = trial;
        end
      end
      return longint'(root);
    endfunction

    // All shifts are arithmetic, so every scaling step rounds toward minus infinity.
    static function refr_result_t predict_refraction(ray_t r);
      longint iv[3];
      longint nv[3];
      longint eta;
      longint one2;
      longint dot;
      longint c;
      longint om;
      longint e2;
      longint k;
      longint mu;
      longint acc;
      comp_t  tmp;
      refr_result_t res;
      int i;
      res  = '0;
      eta  = longint'(r.eta);
      one2 = longint'(1) << (2 * FRAC);
      dot  = 0;
      for (i = 0; i < 3; i++) begin
        tmp   = r.inc[i];
        iv[i] = tmp;
        tmp   = r.nrm[i];
        nv[i] = tmp;
        dot  += iv[i] * nv[i];
      end
      c  = dot >>> FRAC;
      om = (one2 - c * c) >>> FRAC;
      e2 = (eta * eta) >>> FRAC;
      k  = one2 - e2 * om;
      if (k < 0) begin
        res.tir = 1'b1;
        return res;
      end
      mu = ((eta * c) >>> FRAC) + floor_root(k);
      for (i = 0; i < 3; i++) begin
        acc = (eta * iv[i] - mu * nv[i]) >>> FRAC;
        if (acc > 32767) begin
          acc     = 32767;
          res.sat = 1'b1;
        end else if (acc < -32768) begin
          acc     = -32768;
          res.sat = 1'b1;
        end
        res.dir[i] = comp_t'(acc);
      end
      return res;
    endfunction

    function void note_input(ray_t r);
      expected_refr.push_back(predict_refraction(r));
      n_rays++;
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_result(refr_result_t got);
      refr_result_t want;
      int i;
      if (expected_refr.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: x=%0d y=%0d z=%0d tir=%0b sat=%0b",
                                  $signed(got.dir[0]), $signed(got.dir[1]),
                                  $signed(got.dir[2]), got.tir, got.sat));
        return;
      end
      want = expected_refr.pop_front();
      n_checked++;
      if (want.tir) begin
        n_tir++;
      end
      if (want.sat) begin
        n_sat++;
      end
      for (i = 0; i < 3; i++) begin
        if (got.dir[i] !== want.dir[i]) begin
          report_mismatch($sformatf("result %0d component %0d: got %0d, want %0d",
                                    n_checked, i, $signed(got.dir[i]),
                                    $signed(want.dir[i])));
        end
      end
      if (got.tir !== want.tir) begin
        report_mismatch($sformatf("result %0d total_internal: got %0b, want %0b",
                                  n_checked, got.tir, want.tir));
      end
      if (got.sat !== want.sat) begin
        report_mismatch($sformatf("result %0d saturated: got %0b, want %0b",
                                  n_checked, got.sat, want.sat));
      end
    endtask

    function int outstanding();
      return expected_refr.size();
    endfunction
  endclass

endpackage

### tb/sv/tb_vector_refraction.sv
`timescale 1ns / 1ps
module tb_vector_refraction;
  import vrefr_pkg::*;
  import vrefr_tb_pkg::*;

  // The run moves through several handshake regimes. Each regime sets how often
  // the sender inserts an idle cycle and how often the receiver stalls.
  typedef enum int {
    PH_FREE,
    PH_PRESSURE,
    PH_SRC_IDLE,
    PH_SINK_STALL,
    PH_BOTH
  } tb_phase_t;

  localparam int RAYS_PER_PHASE = 377;
  localparam int HOLD_CYCLES    = 300;
  // The pipeline is 35 stages deep; the tail wait covers that with margin.
  localparam int TAIL_CYCLES    = 60;
  localparam int CYCLE_LIMIT    = 100000;

  logic  clk                = 1'b0;
  logic  rst_n              = 1'b0;
  logic  in_valid           = 1'b0;
  comp_t in_incident_x      = '0;
  comp_t in_incident_y      = '0;
  comp_t in_incident_z      = '0;
  comp_t in_normal_x        = '0;
  comp_t in_normal_y        = '0;
  comp_t in_normal_z        = '0;
  logic [ETA_W-1:0] in_eta_ratio = '0;
  logic  out_stall          = 1'b0;

  logic  in_stall;
  logic  out_valid;
  comp_t out_refracted_x;
  comp_t out_refracted_y;
  comp_t out_refracted_z;
  logic  out_total_internal;
  logic  out_saturated;

  tb_phase_t phase          = PH_FREE;
  int        src_idle_pct   = 0;
  int        sink_stall_pct = 0;
  int        hold_left      = 0;
  bit        hold_done      = 1'b0;
  int        cycle_count    = 0;
  int        n_directed     = 0;

  refraction_scoreboard sb = new();

  vector_refraction #(
    .FRAC_BITS(FRAC)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_incident_x     (in_incident_x),
    .in_incident_y     (in_incident_y),
    .in_incident_z     (in_incident_z),
    .in_normal_x       (in_normal_x),
    .in_normal_y       (in_normal_y),
    .in_normal_z       (in_normal_z),
    .in_eta_ratio      (in_eta_ratio),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_refracted_x   (out_refracted_x),
    .out_refracted_y   (out_refracted_y),
    .out_refracted_z   (out_refracted_z),
    .out_total_internal(out_total_internal),
    .out_saturated     (out_saturated)
  );

  always #1 clk = ~clk;

  // Watchdog. A correct run finishes in a small fraction of this many cycles.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_vector_refraction: done, errors");
      $finish;
    end
  end

  // Receiver stall. In the pressure phase the receiver first holds off for a
  // long stretch, counted here, so the pipeline fills and pushes back on the
  // sender; otherwise it stalls at random at the rate of the current phase.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (phase == PH_PRESSURE && !hold_done) begin
      hold_left <= HOLD_CYCLES - 1;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < sink_stall_pct);
    end
  end

  // Result monitor. Reading right after the edge sees the values the edge
  // sampled, so a result counts exactly when valid was high and stall low.
  always @(posedge clk) begin
    refr_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.dir[0] = out_refracted_x;
      got.dir[1] = out_refracted_y;
      got.dir[2] = out_refracted_z;
      got.tir    = out_total_internal;
      got.sat    = out_saturated;
      sb.check_result(got);
    end
  end

  // Offer one ray, possibly after some idle cycles, and hold it until the
  // block takes it. The scoreboard learns about the ray only on acceptance.
  task automatic send_ray(ray_t r);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_incident_x <= r.inc[0];
    in_incident_y <= r.inc[1];
    in_incident_z <= r.inc[2];
    in_normal_x   <= r.nrm[0];
    in_normal_y   <= r.nrm[1];
    in_normal_z   <= r.nrm[2];
    in_eta_ratio  <= r.eta;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    sb.note_input(r);
  endtask

  function automatic ray_t mk_ray(int ix, int iy, int iz, int nx, int ny, int nz, int e);
    ray_t r;
    r.inc[0] = comp_t'(ix);
    r.inc[1] = comp_t'(iy);
    r.inc[2] = comp_t'(iz);
    r.nrm[0] = comp_t'(nx);
    r.nrm[1] = comp_t'(ny);
    r.nrm[2] = comp_t'(nz);
    r.eta    = ETA_W'(e);
    return r;
  endfunction

  task automatic send_directed(ray_t r);
    send_ray(r);
    n_directed++;
  endtask

  // Most random rays look like real geometry: components within about one unit
  // and an index ratio between one half and two, which gives a healthy share of
  // total internal reflection. The rest use the full range of every field, so
  // every input bit toggles and the saturation paths are exercised.
  function automatic ray_t random_ray();
    ray_t r;
    int   sel;
    int   i;
    sel = $urandom_range(99, 0);
    for (i = 0; i < 3; i++) begin
      if (sel < 60) begin
        r.inc[i] = comp_t'(int'($urandom_range(8192, 0)) - 4096);
        r.nrm[i] = comp_t'(int'($urandom_range(8192, 0)) - 4096);
      end else begin
        r.inc[i] = comp_t'($urandom);
        r.nrm[i] = comp_t'($urandom);
      end
    end
    if (sel < 60) begin
      r.eta = ETA_W'($urandom_range(8192, 2048));
    end else begin
      r.eta = ETA_W'($urandom_range(32767, 0));
    end
    return r;
  endfunction

  initial begin
    tb_phase_t ph;
    int n;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rays. Unit vectors are 4096 in Q4.12 and an index ratio of one
    // is also 4096.
    // Head-on ray through a matched interface comes straight through.
    send_directed(mk_ray(0, -4096, 0, 0, 4096, 0, 4096));
    // Oblique ray at 45 degrees into a denser medium.
    send_directed(mk_ray(2896, -2896, 0, 0, 4096, 0, 3072));
    // Same angle from a denser medium at ratio 1.5: total internal reflection.
    send_directed(mk_ray(2896, -2896, 0, 0, 4096, 0, 6144));
    // Grazing ray with a ratio of one makes k exactly zero.
    send_directed(mk_ray(4096, 0, 0, 0, 4096, 0, 4096));
    // Zero ratio: only the square-root term survives.
    send_directed(mk_ray(1234, -2345, 3456, 0, 0, 4096, 0));
    // Zero vectors.
    send_directed(mk_ray(0, 0, 0, 0, 0, 0, 4096));
    send_directed(mk_ray(0, 0, 0, 0, 0, 0, 32767));
    // Largest ratio with a perpendicular normal reflects totally.
    send_directed(mk_ray(4096, 0, 0, 0, 0, 4096, 32767));
    // Cosine above one from vectors longer than a unit.
    send_directed(mk_ray(8192, 0, 0, 8192, 0, 0, 4096));
    // Field extremes. The first three drive the outputs into saturation both ways.
    send_directed(mk_ray(32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_directed(mk_ray(-32768, -32768, -32768, -32768, -32768, -32768, 32767));
    send_directed(mk_ray(-32768, 32767, -32768, 32767, -32768, 32767, 32767));
    send_directed(mk_ray(32767, -32768, 0, -32768, 32767, 0, 1));
    // A dot product of minus one checks that scaling rounds down, not to zero.
    send_directed(mk_ray(-1, 0, 0, 1, 0, 0, 4096));
    // Smallest nonzero ratio and the top ratio bit alone.
    send_directed(mk_ray(-4096, -4096, 0, 0, 4096, 0, 1));
    send_directed(mk_ray(1000, -3000, 500, 0, 4096, 0, 16384));
    // Alternating bit patterns.
    send_directed(mk_ray(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 15'h2AAA));
    send_directed(mk_ray(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 15'h5555));

    // Random rays under each handshake regime in turn.
    for (int p = 0; p < 5; p++) begin
      ph = tb_phase_t'(p);
      phase <= ph;
      case (ph)
        PH_SRC_IDLE: begin
          src_idle_pct   <= 67;
          sink_stall_pct <= 0;
        end
        PH_SINK_STALL: begin
          src_idle_pct   <= 0;
          sink_stall_pct <= 67;
        end
        PH_BOTH: begin
          src_idle_pct   <= 10;
          sink_stall_pct <= 10;
        end
        default: begin
          src_idle_pct   <= 0;
          sink_stall_pct <= 0;
        end
      endcase
      for (n = 0; n < RAYS_PER_PHASE; n++) begin
        send_ray(random_ray());
      end
    end

    // Drain: stop offering, let the receiver run freely and wait for every
    // pending result, then a little longer to catch any stray extra result.
    in_valid       <= 1'b0;
    sink_stall_pct <= 0;
    while (sb.outstanding() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d rays (%0d directed) under free flow, a %0d-cycle output hold,",
             sb.n_rays, n_directed, HOLD_CYCLES);
    $display("  sender gaps, receiver stalls and mixed idling; %0d results checked, %0d %s %0d %s",
             sb.n_checked, sb.n_tir, "total internal reflection,", sb.n_sat, "saturated.");
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb_vector_refraction: done, clean");
    end else begin
      $display("tb_vector_refraction: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
design/vrefr_pkg.sv
design/vector_refraction.sv
tb/sv/vrefr_tb_pkg.sv
tb/sv/tb_vector_refraction.sv
